// ----- hw/rtl/esmm_pkg.sv -----
// Shared types, constants and helper functions for the engine speed motor model.
// Used by the controller, the datapath, the iterative units and the top level.
package esmm_pkg;

  localparam int unsigned DIVW  = 48;  // dividend and quotient width
  localparam int unsigned DSRW  = 32;  // divisor width
  localparam int unsigned SQRW  = 48;  // radicand width
  localparam int unsigned ROOTW = SQRW / 2;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [31:0] RATIO_EPS = 32'd65;  // 0.001 in Q16.16
  localparam logic [30:0] POS_MAX31 = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CFG_MAX_FORCE,
    CFG_INERTIA,
    CFG_DRAG,
    CFG_FRICTION,
    CFG_GEAR_RATIO,
    CFG_SPEED_LIMIT,
    CFG_STALL_SPEED
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FMAX,
    MUL_PUSH,
    MUL_SLOW,
    MUL_FORCE,
    MUL_VEL,
    MUL_FBA,
    MUL_FBB
  } mul_op_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_INR,
    DIV_RATIO
  } div_op_e;

  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_IDLE,
    CAP_GAS,
    CAP_FMAX,
    CAP_PUSH,
    CAP_SLOW,
    CAP_SPEED,
    CAP_VEL,
    CAP_FORCE,
    CAP_B,
    CAP_FB
  } cap_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_IDIV,
    ST_IDIV_W,
    ST_SQRT,
    ST_SQRT_W,
    ST_MUL_FMAX,
    ST_CAP_FMAX,
    ST_MUL_PUSH,
    ST_PDIV,
    ST_PDIV_W,
    ST_SDIV,
    ST_SDIV_W,
    ST_UPD,
    ST_MUL_FORCE,
    ST_FDIV,
    ST_VEL,
    ST_FDIV_W,
    ST_MUL_A,
    ST_ADIV,
    ST_BCAP,
    ST_ADIV_W,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    load_in;
    mul_op_e mul_op;
    logic    div_start;
    div_op_e div_op;
    logic    sqrt_start;
    cap_e    cap;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic ratio_ok;
    logic div_busy;
    logic div_done;
    logic sqrt_done;
  } stat_t;

  // Saturate a wide signed value to 32-bit signed.
  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate an unsigned quotient to 31 bits.
  function automatic logic [30:0] sat_u31(input logic [DIVW-1:0] v);
    logic [30:0] r;
    if (v > {{(DIVW-31){1'b0}}, POS_MAX31}) begin
      r = POS_MAX31;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/esmm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on esmm_pkg for the operand widths.
module esmm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [esmm_pkg::DIVW-1:0] dividend_i,
  input  logic [esmm_pkg::DSRW-1:0] divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [esmm_pkg::DIVW-1:0] quot_o
);
  import esmm_pkg::*;

  localparam int unsigned CNTW = $clog2(DIVW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DIVW-1:0] dvd_q, dvd_d;
  logic [DSRW-1:0] rem_q, rem_d;
  logic [DSRW-1:0] dsr_q, dsr_d;
  logic [DSRW:0]   rem_sh;
  logic [DSRW:0]   rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, dvd_q[DIVW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DIVW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // The dividend register fills with quotient bits from the bottom.
      dvd_d = {dvd_q[DIVW-2:0], ge};
      rem_d = ge ? rem_sub[DSRW-1:0] : rem_sh[DSRW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- hw/rtl/esmm_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on esmm_pkg for the radicand and root widths.
module esmm_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [esmm_pkg::SQRW-1:0]  radicand_i,
  output logic                      done_o,
  output logic [esmm_pkg::ROOTW-1:0] root_o
);
  import esmm_pkg::*;

  localparam int unsigned CNTW = $clog2(ROOTW);
  localparam int unsigned REMW = ROOTW + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [SQRW-1:0]  rad_q, rad_d;
  logic [REMW-1:0]  rem_q, rem_d;
  logic [ROOTW-1:0] root_q, root_d;
  logic [REMW+1:0]  rem_sh;
  logic [REMW+1:0]  trial;
  logic [REMW+1:0]  rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, rad_q[SQRW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign ge      = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(ROOTW - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[SQRW-3:0], 2'b00};
      rem_d  = ge ? rem_sub[REMW-1:0] : rem_sh[REMW-1:0];
      root_d = {root_q[ROOTW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/esmm_dp.sv -----
// Datapath: configuration registers, engine speed state, shared multiplier,
// divider and square root units, output word register. Depends on esmm_pkg.
module esmm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 action_i,
  input  logic [16:0]          step_size_i,
  input  logic [16:0]          throttle_i,
  input  logic signed [31:0]   target_speed_i,
  input  logic signed [31:0]   joint_speed_i,
  input  esmm_pkg::cmd_t       cmd_i,
  output esmm_pkg::stat_t      stat_o,
  output logic signed [31:0]   joint_velocity_o,
  output logic [30:0]          joint_force_o,
  output logic signed [31:0]   engine_speed_o
);
  import esmm_pkg::*;

  // Configuration
  logic [30:0]        max_force_q, inertia_q, drag_q, speed_limit_q, stall_speed_q;
  logic [16:0]        friction_q;
  logic signed [31:0] gear_ratio_q;

  // Item and working registers
  logic               action_q;
  logic [16:0]        step_q, thr_q;
  logic signed [31:0] target_q, joint_q, speed_q;
  logic signed [63:0] prod_q;
  logic [30:0]        idle_q, fmax_q, force_q;
  logic [ROOTW-1:0]   gas_q;
  logic [32:0]        push_q;
  logic [31:0]        slow_q;
  logic signed [31:0] vel_q;
  logic signed [32:0] b_q;
  logic               neg_q;
  logic signed [31:0] out_vel_q, out_speed_q;
  logic [30:0]        out_force_q;

  logic [16:0]        fric;
  logic [31:0]        ratio_mag;
  logic [30:0]        inr;
  logic [31:0]        s_mag;
  logic signed [32:0] dv;
  logic [32:0]        dv_mag;
  logic [32:0]        idle_diff;
  logic [30:0]        fdiff;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic [63:0]        prod_mag;
  logic signed [63:0] prod_t16;
  logic [DIVW-1:0]    div_dvd, quot;
  logic [DSRW-1:0]    div_dsr;
  logic               div_busy, div_done, sqrt_done;
  logic [ROOTW-1:0]   root;
  logic signed [35:0] upd_sum;
  logic signed [49:0] fb_a, fb_sum;

  assign fric      = (friction_q > ONE_Q16) ? ONE_Q16 : friction_q;
  assign ratio_mag = gear_ratio_q[31] ? (~gear_ratio_q + 32'd1) : gear_ratio_q;
  assign inr       = (inertia_q == '0) ? 31'd1 : inertia_q;
  assign s_mag     = speed_q[31] ? (~speed_q + 32'd1) : speed_q;
  assign dv        = {target_q[31], target_q} - {speed_q[31], speed_q};
  assign dv_mag    = dv[32] ? (~dv + 33'd1) : dv;
  assign idle_diff = ($signed({speed_q[31], speed_q}) < $signed({2'b00, stall_speed_q}))
                     ? ({2'b00, stall_speed_q} - {speed_q[31], speed_q}) : '0;
  assign fdiff     = (fmax_q >= drag_q) ? (fmax_q - drag_q) : (drag_q - fmax_q);
  assign prod_mag  = prod_q[63] ? (~prod_q + 64'd1) : prod_q;
  // Divide by 2^16 rounding toward zero.
  assign prod_t16  = (prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0)) >>> 16;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_FMAX: begin
        mul_a = $signed({2'b00, max_force_q});
        mul_b = $signed({{(33-ROOTW){1'b0}}, gas_q});
      end
      MUL_PUSH: begin
        mul_a = $signed({16'b0, step_q});
        mul_b = $signed({2'b00, fmax_q});
      end
      MUL_SLOW: begin
        mul_a = $signed({16'b0, step_q});
        mul_b = $signed({2'b00, drag_q});
      end
      MUL_FORCE: begin
        mul_a = $signed({2'b00, fdiff});
        mul_b = $signed({16'b0, fric});
      end
      MUL_VEL: begin
        mul_a = {speed_q[31], speed_q};
        mul_b = {gear_ratio_q[31], gear_ratio_q};
      end
      MUL_FBA: begin
        mul_a = $signed({16'b0, fric});
        mul_b = {joint_q[31], joint_q};
      end
      MUL_FBB: begin
        mul_a = $signed({16'b0, ONE_Q16 - fric});
        mul_b = {speed_q[31], speed_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    div_dvd = '0;
    div_dsr = '0;
    case (cmd_i.div_op)
      DIV_IDLE: begin
        div_dvd = {idle_diff[31:0], 16'b0};
        div_dsr = {1'b0, stall_speed_q};
      end
      DIV_INR: begin
        div_dvd = prod_q[DIVW-1:0];
        div_dsr = {1'b0, inr};
      end
      DIV_RATIO: begin
        div_dvd = prod_mag[DIVW-1:0];
        div_dsr = ratio_mag;
      end
      default: begin
        div_dvd = '0;
        div_dsr = '0;
      end
    endcase
  end

  esmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  esmm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i ({1'b0, idle_q, 16'b0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Push never exceeds the distance to the target and slow never exceeds the
  // speed magnitude, so the sign factors reduce to the sign bits.
  assign upd_sum = 36'(speed_q)
                 + (dv[32] ? -36'($signed({1'b0, push_q})) : 36'($signed({1'b0, push_q})))
                 - (speed_q[31] ? -36'($signed({1'b0, slow_q}))
                                : 36'($signed({1'b0, slow_q})));
  assign fb_a    = neg_q ? -50'($signed({1'b0, quot})) : 50'($signed({1'b0, quot}));
  assign fb_sum  = fb_a + 50'(b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_force_q   <= '0;
      inertia_q     <= 31'd65536;
      drag_q        <= '0;
      friction_q    <= '0;
      gear_ratio_q  <= 32'sd65536;
      speed_limit_q <= POS_MAX31;
      stall_speed_q <= '0;
      speed_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_FORCE:   max_force_q   <= cfg_wdata_i[30:0];
          CFG_INERTIA:     inertia_q     <= cfg_wdata_i[30:0];
          CFG_DRAG:        drag_q        <= cfg_wdata_i[30:0];
          CFG_FRICTION:    friction_q    <= cfg_wdata_i[16:0];
          CFG_GEAR_RATIO:  gear_ratio_q  <= cfg_wdata_i;
          CFG_SPEED_LIMIT: speed_limit_q <= cfg_wdata_i[30:0];
          CFG_STALL_SPEED: stall_speed_q <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
      if (cmd_i.cap == CAP_SPEED) begin
        speed_q <= sat_s32(64'(upd_sum));
      end else if (cmd_i.cap == CAP_FB) begin
        speed_q <= sat_s32(64'(fb_sum));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= action_i;
      step_q   <= step_size_i;
      thr_q    <= (throttle_i > ONE_Q16) ? ONE_Q16 : throttle_i;
      target_q <= target_speed_i;
      joint_q  <= joint_speed_i;
      vel_q    <= '0;
      force_q  <= '0;
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= prod_full[63:0];
    end
    if (cmd_i.div_start) begin
      neg_q <= prod_q[63] ^ gear_ratio_q[31];
    end
    case (cmd_i.cap)
      CAP_IDLE:  idle_q <= (stall_speed_q == '0) ? '0 : sat_u31(quot);
      CAP_GAS:   gas_q  <= (root > ROOTW'(thr_q)) ? root : ROOTW'(thr_q);
      CAP_FMAX:  fmax_q <= sat_u31(prod_q[DIVW+15:16]);
      CAP_PUSH: begin
        if ({1'b0, s_mag} < {2'b00, speed_limit_q}) begin
          push_q <= (quot > DIVW'(dv_mag)) ? dv_mag : quot[32:0];
        end else begin
          push_q <= '0;
        end
      end
      CAP_SLOW:  slow_q <= (quot > DIVW'(s_mag)) ? s_mag : quot[31:0];
      CAP_VEL:   vel_q  <= (fmax_q >= drag_q) ? sat_s32(prod_t16) : '0;
      CAP_FORCE: force_q <= sat_u31(quot);
      CAP_B:     b_q    <= prod_t16[32:0];
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_vel_q   <= vel_q;
      out_force_q <= force_q;
      out_speed_q <= speed_q;
    end
  end

  assign stat_o.action    = action_q;
  assign stat_o.ratio_ok  = ratio_mag > RATIO_EPS;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;

  assign joint_velocity_o = out_vel_q;
  assign joint_force_o    = out_force_q;
  assign engine_speed_o   = out_speed_q;

endmodule

// ----- hw/rtl/esmm_ctrl.sv -----
// Controller: sequences the datapath through one word at a time and owns the
// handshakes of both channels. Depends on esmm_pkg.
module esmm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  esmm_pkg::stat_t  stat_i,
  output esmm_pkg::cmd_t   cmd_o
);
  import esmm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_START;
      ST_START: begin
        if (!stat_i.action)       state_d = ST_IDIV;
        else if (stat_i.ratio_ok) state_d = ST_MUL_A;
        else                      state_d = ST_DONE;
      end
      ST_IDIV:      state_d = ST_IDIV_W;
      ST_IDIV_W:    if (stat_i.div_done) state_d = ST_SQRT;
      ST_SQRT:      state_d = ST_SQRT_W;
      ST_SQRT_W:    if (stat_i.sqrt_done) state_d = ST_MUL_FMAX;
      ST_MUL_FMAX:  state_d = ST_CAP_FMAX;
      ST_CAP_FMAX:  state_d = ST_MUL_PUSH;
      ST_MUL_PUSH:  state_d = ST_PDIV;
      ST_PDIV:      state_d = ST_PDIV_W;
      ST_PDIV_W:    if (stat_i.div_done) state_d = ST_SDIV;
      ST_SDIV:      state_d = ST_SDIV_W;
      ST_SDIV_W:    if (stat_i.div_done) state_d = ST_UPD;
      ST_UPD:       state_d = stat_i.ratio_ok ? ST_MUL_FORCE : ST_DONE;
      ST_MUL_FORCE: state_d = ST_FDIV;
      ST_FDIV:      state_d = ST_VEL;
      ST_VEL:       state_d = ST_FDIV_W;
      ST_FDIV_W:    if (stat_i.div_done) state_d = ST_DONE;
      ST_MUL_A:     state_d = ST_ADIV;
      ST_ADIV:      state_d = ST_BCAP;
      ST_BCAP:      state_d = ST_ADIV_W;
      ST_ADIV_W:    if (stat_i.div_done) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:      cmd_o.load_in = in_valid_i;
      ST_IDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_IDLE;
      end
      ST_IDIV_W:    if (stat_i.div_done) cmd_o.cap = CAP_IDLE;
      ST_SQRT:      cmd_o.sqrt_start = 1'b1;
      ST_SQRT_W:    if (stat_i.sqrt_done) cmd_o.cap = CAP_GAS;
      ST_MUL_FMAX:  cmd_o.mul_op = MUL_FMAX;
      ST_CAP_FMAX:  cmd_o.cap = CAP_FMAX;
      ST_MUL_PUSH:  cmd_o.mul_op = MUL_PUSH;
      ST_PDIV: begin
        // The divider takes its operands now, so the multiplier is free.
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_INR;
        cmd_o.mul_op    = MUL_SLOW;
      end
      ST_PDIV_W:    if (stat_i.div_done) cmd_o.cap = CAP_PUSH;
      ST_SDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_INR;
      end
      ST_SDIV_W:    if (stat_i.div_done) cmd_o.cap = CAP_SLOW;
      ST_UPD:       cmd_o.cap = CAP_SPEED;
      ST_MUL_FORCE: cmd_o.mul_op = MUL_FORCE;
      ST_FDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RATIO;
        cmd_o.mul_op    = MUL_VEL;
      end
      ST_VEL:       cmd_o.cap = CAP_VEL;
      ST_FDIV_W:    if (stat_i.div_done) cmd_o.cap = CAP_FORCE;
      ST_MUL_A:     cmd_o.mul_op = MUL_FBA;
      ST_ADIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RATIO;
        cmd_o.mul_op    = MUL_FBB;
      end
      ST_BCAP:      cmd_o.cap = CAP_B;
      ST_ADIV_W:    if (stat_i.div_done) cmd_o.cap = CAP_FB;
      ST_DONE:      cmd_o.out_load = out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/engine_speed_motor_model.sv -----
// Engine speed motor model, one word in flight. A propagate word uses the shared
// divider up to four times and the root once, a feedback word uses it at most once;
// the next word is taken when the sequencer is idle.
// Results wait in an output register, so a new word can start while one is held.
// Reset (asynchronous, active low) restores register defaults and a zero speed.
module engine_speed_motor_model (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [16:0]         step_size_i,
  input  logic [16:0]         throttle_i,
  input  logic signed [31:0]  target_speed_i,
  input  logic signed [31:0]  joint_speed_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  joint_velocity_o,
  output logic [30:0]         joint_force_o,
  output logic signed [31:0]  engine_speed_o
);
  import esmm_pkg::*;

  cmd_t   cmd;
  stat_t  stat;

  esmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  esmm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .step_size_i      (step_size_i),
    .throttle_i       (throttle_i),
    .target_speed_i   (target_speed_i),
    .joint_speed_i    (joint_speed_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .joint_velocity_o (joint_velocity_o),
    .joint_force_o    (joint_force_o),
    .engine_speed_o   (engine_speed_o)
  );

  // An accepted word keeps the input side closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word is in progress");

  // The divider is never restarted while it still iterates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // The output register is only loaded when the previous word has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output word overwritten");

endmodule

// ----- sim/engine_speed_motor_model_test.sv -----
// Self-checking testbench for engine_speed_motor_model: directed table, then random words.
// Depends on esmm_pkg and the RTL of the block; it needs no other file.
module engine_speed_motor_model_test;
  timeunit 1ns;
  timeprecision 1ps;
  import esmm_pkg::*;

  localparam logic ACT_PROPAGATE = 1'b0;
  localparam logic ACT_FEEDBACK  = 1'b1;
  localparam int   DRAIN_CYCLES  = 300;
  localparam int   HOLD_CYCLES   = 2500;
  localparam int   STUCK_LIMIT   = 20000;
  localparam int   PHASES        = 8;
  localparam int   PHASE_WORDS   = 180;

  typedef struct packed {
    logic signed [31:0] vel;
    logic [30:0]        jforce;
    logic signed [31:0] speed;
  } motion_t;

  typedef struct {
    logic [31:0] mf, inr, drg, fric, ratio, lim, stall;
  } cfg_set_t;

  typedef struct {
    int                 cfg;
    logic               act;
    logic [16:0]        step, thr;
    logic signed [31:0] tgt, jnt;
    bit                 typed;
    motion_t            res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic [16:0] step_size_i = '0;
  logic [16:0] throttle_i = '0;
  logic signed [31:0] target_speed_i = '0;
  logic signed [31:0] joint_speed_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] joint_velocity_o;
  logic [30:0] joint_force_o;
  logic signed [31:0] engine_speed_o;

  engine_speed_motor_model i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model copy of the registers and the engine speed.
  longint mf_q, inr_q, drg_q, fric_q, ratio_q, lim_q, stall_q, speed_q;
  motion_t pending_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;

  function automatic longint sat32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sgn(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint int_root(input longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advances the engine speed by one word and returns the joint command it yields.
  function automatic motion_t advance_engine(input logic act, input logic [16:0] stp,
                                             input logic [16:0] thr_in,
                                             input logic signed [31:0] tgt,
                                             input logic signed [31:0] jnt);
    longint s, dv, m, thr, fric, rmag, inr, idle, gas, fmax, push, slow, vel, frc;
    motion_t r;
    bit ratio_ok;
    s = speed_q;
    thr = (thr_in > 65536) ? 65536 : longint'(thr_in);
    fric = (fric_q > 65536) ? 65536 : fric_q;
    rmag = mag(ratio_q);
    ratio_ok = rmag > 65;
    vel = 0;
    frc = 0;
    if (act == ACT_PROPAGATE) begin
      inr = (inr_q != 0) ? inr_q : 1;
      idle = 0;
      dv = longint'(tgt) - s;
      if (stall_q != 0) begin
        m = (s < stall_q) ? s : stall_q;
        idle = ((stall_q - m) << 16) / stall_q;
        if (idle > 64'h7FFF_FFFF) idle = 64'h7FFF_FFFF;
      end
      gas = int_root(idle << 16);
      if (thr > gas) gas = thr;
      fmax = (mf_q * gas) >>> 16;
      if (fmax > 64'h7FFF_FFFF) fmax = 64'h7FFF_FFFF;
      push = longint'(stp) * fmax / inr;
      if (push > mag(dv)) push = mag(dv);
      if (!(mag(s) < lim_q)) push = 0;
      slow = longint'(stp) * drg_q / inr;
      if (slow > mag(s)) slow = mag(s);
      s = sat32(s + push * sgn(dv) - slow * sgn(s));
      speed_q = s;
      if (ratio_ok) begin
        frc = (mag(fmax - drg_q) * fric) / rmag;
        if (frc > 64'h7FFF_FFFF) frc = 64'h7FFF_FFFF;
        if (fmax >= drg_q) vel = sat32((s * ratio_q) / 65536);
      end
    end else if (ratio_ok) begin
      speed_q = sat32((fric * longint'(jnt)) / ratio_q + ((65536 - fric) * s) / 65536);
    end
    r.vel = vel[31:0];
    r.jforce = frc[30:0];
    r.speed = speed_q[31:0];
    return r;
  endfunction

  // Leaves the write enable high; the caller drops it after the last register.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_FORCE:   mf_q = d[30:0];
      CFG_INERTIA:     inr_q = d[30:0];
      CFG_DRAG:        drg_q = d[30:0];
      CFG_FRICTION:    fric_q = d[16:0];
      CFG_GEAR_RATIO:  ratio_q = longint'($signed(d));
      CFG_SPEED_LIMIT: lim_q = d[30:0];
      CFG_STALL_SPEED: stall_q = d[30:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_set_t c);
    write_reg(CFG_MAX_FORCE, c.mf);
    write_reg(CFG_INERTIA, c.inr);
    write_reg(CFG_DRAG, c.drg);
    write_reg(CFG_FRICTION, c.fric);
    write_reg(CFG_GEAR_RATIO, c.ratio);
    write_reg(CFG_SPEED_LIMIT, c.lim);
    write_reg(CFG_STALL_SPEED, c.stall);
    cfg_we_i <= 1'b0;
  endtask

  // Drops valid in the step of the last acceptance, then waits for every result.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_word(input logic act, input logic [16:0] stp, input logic [16:0] thr,
                           input logic signed [31:0] tgt, input logic signed [31:0] jnt,
                           input bit typed, input motion_t typed_res);
    bit taken;
    motion_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    step_size_i <= stp;
    throttle_i <= thr;
    target_speed_i <= tgt;
    joint_speed_i <= jnt;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    r = advance_engine(act, stp, thr, tgt, jnt);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  function automatic logic [31:0] pick_reg(input cfg_idx_e idx);
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'h7FFF_FFFF;
      default: begin
        case (idx)
          CFG_MAX_FORCE:   return $urandom_range(1, 1000) << 16;
          CFG_INERTIA:     return $urandom_range(1, 40) << 16;
          CFG_DRAG:        return $urandom_range(0, 20) << 16;
          CFG_FRICTION:    return $urandom_range(0, 65536);
          CFG_GEAR_RATIO:  return $urandom_range(0, 3) == 0 ? $urandom_range(0, 130) - 65
                                  : ($urandom_range(1, 16) << 14) * ($urandom_range(0, 1) ? 1 : -1);
          CFG_SPEED_LIMIT: return $urandom_range(50, 3000) << 16;
          default:         return $urandom_range(0, 100) << 16;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_speed(input logic signed [31:0] near);
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return near + $signed($urandom_range(0, 400 << 16)) - (200 <<< 16);
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off on request.
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Results are compared at the falling edge, where every signal is settled.
  int stuck = 0;
  always @(negedge clk_i) begin
    motion_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word vel %0d force %0d speed %0d", $time,
                 joint_velocity_o, joint_force_o, engine_speed_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (joint_velocity_o !== want.vel) begin
          $display("%0t: joint_velocity expected %0d actual %0d", $time, want.vel,
                   joint_velocity_o);
          errors++;
        end
        if (joint_force_o !== want.jforce) begin
          $display("%0t: joint_force expected %0d actual %0d", $time, want.jforce,
                   joint_force_o);
          errors++;
        end
        if (engine_speed_o !== want.speed) begin
          $display("%0t: engine_speed expected %0d actual %0d", $time, want.speed,
                   engine_speed_o);
          errors++;
        end
      end
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) || !rst_ni) begin
      stuck = 0;
    end else if (++stuck >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  cfg_set_t dir_cfg[4];
  row_t rows[$];

  task automatic add_row(input int c, input logic act, input logic [16:0] stp,
                         input logic [16:0] thr, input logic signed [31:0] tgt,
                         input logic signed [31:0] jnt);
    row_t r;
    r = '{c, act, stp, thr, tgt, jnt, 0, '0};
    rows.push_back(r);
  endtask

  initial begin
    cfg_set_t c;
    row_t r;
    int cur_cfg;
    logic act;
    mf_q = 0; inr_q = 65536; drg_q = 0; fric_q = 0;
    ratio_q = 65536; lim_q = 64'h7FFF_FFFF; stall_q = 0; speed_q = 0;

    // Reset values give zero force and keep the engine at rest.
    dir_cfg[0] = '{0, 65536, 0, 0, 65536, 32'h7FFF_FFFF, 0};
    dir_cfg[1] = '{200 << 16, 2 << 16, 1 << 16, 32'h8000, 3 << 16, 500 << 16, 50 << 16};
    // Ratio too small, zero inertia, friction above one, fmax below drag.
    dir_cfg[2] = '{10 << 16, 0, 32'h7FFF_FFFF, 32'h1_FFFF, -65, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF};
    dir_cfg[3] = '{32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 32'h1_FFFF, 32'h8000_0000, 0, 1 << 16};

    r = '{0, ACT_PROPAGATE, 17'd0, 17'd0, 32'sd0, 32'sd0, 1, '0};
    rows.push_back(r);
    r = '{0, ACT_PROPAGATE, 17'h1_FFFF, 17'h1_FFFF, 32'sh7FFF_FFFF, 32'sd0, 1, '0};
    rows.push_back(r);
    r = '{0, ACT_FEEDBACK, 17'd0, 17'd0, 32'sd0, 32'sh7FFF_FFFF, 1, '0};
    rows.push_back(r);
    add_row(1, ACT_PROPAGATE, 17'd65536, 17'd32768, 100 <<< 16, 0);
    add_row(1, ACT_PROPAGATE, 17'h1_FFFF, 17'h1_FFFF, 32'sh7FFF_FFFF, 0);
    add_row(1, ACT_PROPAGATE, 17'd65536, 17'd65536, 32'sh7FFF_FFFF, 0);
    add_row(1, ACT_PROPAGATE, 17'd65536, 17'd65536, 32'sh7FFF_FFFF, 0);
    add_row(1, ACT_PROPAGATE, 17'd0, 17'd0, 32'sh8000_0000, 0);
    add_row(1, ACT_FEEDBACK, 17'd0, 17'd0, 0, 32'sh7FFF_FFFF);
    add_row(1, ACT_PROPAGATE, 17'h1_FFFF, 17'd0, 32'sh8000_0000, 0);
    add_row(1, ACT_PROPAGATE, 17'h1_FFFF, 17'd0, 32'sh8000_0000, 0);
    add_row(1, ACT_FEEDBACK, 17'h1_FFFF, 17'h1_FFFF, 0, 32'sh8000_0000);
    add_row(1, ACT_PROPAGATE, 17'd65536, 17'd0, 0, 0);
    add_row(2, ACT_PROPAGATE, 17'd65536, 17'd65536, 32'sh7FFF_FFFF, 0);
    add_row(2, ACT_FEEDBACK, 17'd0, 17'd0, 0, 32'sh7FFF_FFFF);
    add_row(2, ACT_PROPAGATE, 17'h1_FFFF, 17'h1_FFFF, 32'sh8000_0000, 0);
    add_row(3, ACT_PROPAGATE, 17'h1_FFFF, 17'h1_FFFF, 32'sh7FFF_FFFF, 0);
    add_row(3, ACT_FEEDBACK, 17'd0, 17'd0, 0, 32'sh8000_0000);
    add_row(3, ACT_PROPAGATE, 17'd65536, 17'd0, 32'sh8000_0000, 0);
    add_row(3, ACT_FEEDBACK, 17'd0, 17'd0, 0, 32'sh7FFF_FFFF);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_cfg = 0;
    send_idle_pct = 25;
    recv_stall_pct = 70;
    foreach (rows[i]) begin
      if (rows[i].cfg != cur_cfg) begin
        drain();
        cur_cfg = rows[i].cfg;
        load_config(dir_cfg[cur_cfg]);
      end
      send_word(rows[i].act, rows[i].step, rows[i].thr, rows[i].tgt, rows[i].jnt,
                rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF};
      end else begin
        c.mf = pick_reg(CFG_MAX_FORCE);
        c.inr = pick_reg(CFG_INERTIA);
        c.drg = pick_reg(CFG_DRAG);
        c.fric = pick_reg(CFG_FRICTION);
        c.ratio = pick_reg(CFG_GEAR_RATIO);
        c.lim = pick_reg(CFG_SPEED_LIMIT);
        c.stall = pick_reg(CFG_STALL_SPEED);
      end
      load_config(c);
      send_idle_pct = (ph < 3) ? 25 : ((ph < 6) ? 70 : 0);
      recv_stall_pct = (ph < 3) ? 70 : ((ph < 6) ? 25 : 0);
      if (ph == 1) hold_req = 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        act = ($urandom_range(0, 99) < 15) ? ACT_FEEDBACK : ACT_PROPAGATE;
        send_word(act,
                  ($urandom_range(0, 9) == 0) ? 17'h1_FFFF : $urandom_range(0, 65536),
                  ($urandom_range(0, 7) == 0) ? 17'(
                    $urandom) : $urandom_range(0, 65536),
                  pick_speed(speed_q[31:0]), pick_speed(speed_q[31:0]), 0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
